// ===== design/nsi_pkg.sv =====
// ----------------------------------------------------------------------------
// nsi_pkg
// shared constants and types of the nearest segment intersection block
// ----------------------------------------------------------------------------
package nsi_pkg;

	localparam int MAX_SEGMENTS_DEF = 256;
	localparam int COORD_WIDTH_DEF  = 24;

	// item kinds
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic done;
		logic any;
	} scan_stat_t;

endpackage

// ===== design/nsi_table.sv =====
// ----------------------------------------------------------------------------
// nsi_table
// segment storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module nsi_table #(
	parameter int DEPTH = nsi_pkg::MAX_SEGMENTS_DEF,
	parameter int AW    = 8,
	parameter int DW    = 4 * nsi_pkg::COORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while the scan pipeline is held
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/nsi_scan.sv =====
// ----------------------------------------------------------------------------
// nsi_scan
// walks the stored segments, tests each against the query and keeps the
// hit with the smallest t
// ----------------------------------------------------------------------------
module nsi_scan #(
	parameter int MAX_SEGMENTS = nsi_pkg::MAX_SEGMENTS_DEF,
	parameter int COORD_WIDTH  = nsi_pkg::COORD_WIDTH_DEF,
	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
	localparam int CW = $clog2(MAX_SEGMENTS + 1),
	localparam int W  = COORD_WIDTH,
	localparam int DW = W + 1,
	localparam int PW = 2 * DW,
	localparam int XW = PW + 1,
	localparam int UW = XW - 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [CW-1:0]          count,
	input  logic signed [W-1:0]    x_start,
	input  logic signed [W-1:0]    y_start,
	input  logic signed [W-1:0]    x_end,
	input  logic signed [W-1:0]    y_end,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	input  logic [4*W-1:0]         rd_data,
	output nsi_pkg::scan_stat_t    stat,
	output logic [UW-1:0]          best_tn,
	output logic [UW-1:0]          best_dt
);

	localparam int HW = (UW + 1) / 2;
	localparam int LW = UW - HW;
	localparam int SW = 2 * UW;

	logic          running_q;
	logic [CW-1:0] idx_q;
	logic          more;
	logic          hold;
	logic          adv;
	logic          busy;
	logic          enter;
	logic          done;

	logic signed [DW-1:0] d1x_q, d1y_q;
	logic signed [W-1:0]  xa, ya, xb, yb;

	logic v_s0, v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] d2x_s1, d2y_s1, d3x_s1, d3y_s1;
	logic signed [PW-1:0] pd1_s2, pd2_s2, pt1_s2, pt2_s2, pu1_s2, pu2_s2;
	logic signed [XW-1:0] dt_s3, tn_s3, un_s3;
	logic signed [XW-1:0] dt_s4, tn_s4, un_s4;
	logic                 cand_hit;

	logic          c1_v, c2_v, any_q;
	logic [UW-1:0] ctn_c1, cdt_c1, ctn_c2, cdt_c2;
	logic [2*HW-1:0]   all_c1, bll_c1;
	logic [HW+LW-1:0]  alh_c1, ahl_c1, blh_c1, bhl_c1;
	logic [2*LW-1:0]   ahh_c1, bhh_c1;
	logic [SW-1:0]     sa_c2, sb_c2;
	logic [UW-1:0]     best_tn_q, best_dt_q;

	assign more    = idx_q < count;
	assign busy    = c1_v | c2_v;
	assign hold    = v_s4 & cand_hit & busy;
	assign adv     = ~hold;
	assign enter   = v_s4 & cand_hit & ~busy;
	assign rd_en   = running_q & adv & more;
	assign rd_addr = idx_q[AW-1:0];
	assign done    = running_q & ~more & ~(v_s0 | v_s1 | v_s2 | v_s3 | v_s4) & ~busy;

	assign xa = $signed(rd_data[4*W-1:3*W]);
	assign ya = $signed(rd_data[3*W-1:2*W]);
	assign xb = $signed(rd_data[2*W-1:W]);
	assign yb = $signed(rd_data[W-1:0]);

	// issue side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			idx_q     <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			idx_q     <= '0;
		end else if (done) begin
			running_q <= 1'b0;
		end else if (rd_en) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d1x_q <= DW'(x_start) - DW'(x_end);
			d1y_q <= DW'(y_start) - DW'(y_end);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s0 <= rd_en;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2x_s1 <= DW'(x_start) - DW'(xa);
			d2y_s1 <= DW'(y_start) - DW'(ya);
			d3x_s1 <= DW'(xa) - DW'(xb);
			d3y_s1 <= DW'(ya) - DW'(yb);

			pd1_s2 <= PW'(d1x_q) * PW'(d3y_s1);
			pd2_s2 <= PW'(d1y_q) * PW'(d3x_s1);
			pt1_s2 <= PW'(d2x_s1) * PW'(d3y_s1);
			pt2_s2 <= PW'(d2y_s1) * PW'(d3x_s1);
			pu1_s2 <= PW'(d1y_q) * PW'(d2x_s1);
			pu2_s2 <= PW'(d1x_q) * PW'(d2y_s1);

			dt_s3 <= XW'(pd1_s2) - XW'(pd2_s2);
			tn_s3 <= XW'(pt1_s2) - XW'(pt2_s2);
			un_s3 <= XW'(pu1_s2) - XW'(pu2_s2);

			// fold the sign of the determinant into all three
			dt_s4 <= dt_s3[XW-1] ? -dt_s3 : dt_s3;
			tn_s4 <= dt_s3[XW-1] ? -tn_s3 : tn_s3;
			un_s4 <= dt_s3[XW-1] ? -un_s3 : un_s3;
		end
	end

	assign cand_hit = (dt_s4 != '0) & ~tn_s4[XW-1] & ~un_s4[XW-1]
		& (tn_s4 <= dt_s4) & (un_s4 <= dt_s4);

	// compare tn/dt against best_tn/best_dt by cross products in halves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_v  <= 1'b0;
			c2_v  <= 1'b0;
			any_q <= 1'b0;
		end else begin
			c1_v <= enter;
			c2_v <= c1_v;
			if (start) begin
				any_q <= 1'b0;
			end else if (c2_v) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enter) begin
			ctn_c1 <= tn_s4[UW-1:0];
			cdt_c1 <= dt_s4[UW-1:0];
			all_c1 <= (2*HW)'(tn_s4[HW-1:0]) * (2*HW)'(best_dt_q[HW-1:0]);
			alh_c1 <= (HW+LW)'(tn_s4[HW-1:0]) * (HW+LW)'(best_dt_q[UW-1:HW]);
			ahl_c1 <= (HW+LW)'(tn_s4[UW-1:HW]) * (HW+LW)'(best_dt_q[HW-1:0]);
			ahh_c1 <= (2*LW)'(tn_s4[UW-1:HW]) * (2*LW)'(best_dt_q[UW-1:HW]);
			bll_c1 <= (2*HW)'(best_tn_q[HW-1:0]) * (2*HW)'(dt_s4[HW-1:0]);
			blh_c1 <= (HW+LW)'(best_tn_q[HW-1:0]) * (HW+LW)'(dt_s4[UW-1:HW]);
			bhl_c1 <= (HW+LW)'(best_tn_q[UW-1:HW]) * (HW+LW)'(dt_s4[HW-1:0]);
			bhh_c1 <= (2*LW)'(best_tn_q[UW-1:HW]) * (2*LW)'(dt_s4[UW-1:HW]);
		end
		if (c1_v) begin
			ctn_c2 <= ctn_c1;
			cdt_c2 <= cdt_c1;
			sa_c2  <= SW'(all_c1) + ((SW'(alh_c1) + SW'(ahl_c1)) << HW)
				+ (SW'(ahh_c1) << (2 * HW));
			sb_c2  <= SW'(bll_c1) + ((SW'(blh_c1) + SW'(bhl_c1)) << HW)
				+ (SW'(bhh_c1) << (2 * HW));
		end
		// strict less keeps the earlier segment on equal t
		if (c2_v && (!any_q || sa_c2 < sb_c2)) begin
			best_tn_q <= ctn_c2;
			best_dt_q <= cdt_c2;
		end
	end

	assign best_tn   = best_tn_q;
	assign best_dt   = best_dt_q;
	assign stat.done = done;
	assign stat.any  = any_q;

endmodule

// ===== design/nsi_div.sv =====
// ----------------------------------------------------------------------------
// nsi_div
// hit point along one axis: base + floor(tn * (tip - base) / dt),
// restoring division one quotient bit per cycle
// ----------------------------------------------------------------------------
module nsi_div #(
	parameter int COORD_WIDTH = nsi_pkg::COORD_WIDTH_DEF,
	localparam int W  = COORD_WIDTH,
	localparam int DW = W + 1,
	localparam int UW = 2 * DW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [UW-1:0]       tn,
	input  logic [UW-1:0]       dt,
	input  logic signed [W-1:0] base,
	input  logic signed [W-1:0] tip,
	output logic                done,
	output logic signed [W-1:0] result
);

	localparam int HW = (UW + 1) / 2;
	localparam int LW = UW - HW;
	localparam int NW = UW + DW;
	localparam int KW = $clog2(DW + 1);

	typedef enum logic [4:0] {
		D_IDLE = 5'b00001,
		D_MUL  = 5'b00010,
		D_SUM  = 5'b00100,
		D_DIV  = 5'b01000,
		D_FIN  = 5'b10000
	} dstate_t;

	dstate_t state_q;
	logic [KW-1:0]        cnt_q;
	logic                 neg_q;
	logic [DW-1:0]        mag_q;
	logic [UW-1:0]        tn_q, dt_q;
	logic signed [W-1:0]  base_q;
	logic [HW+DW-1:0]     lo_q;
	logic [LW+DW-1:0]     hi_q;
	logic [NW-1:0]        rem_q, dsh_q;
	logic [DW-1:0]        quo_q;
	logic signed [DW-1:0] diff;
	logic signed [DW:0]   qs;
	logic signed [DW:0]   sum;

	assign diff = DW'(tip) - DW'(base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: state_q <= D_SUM;
				D_SUM: begin
					state_q <= D_DIV;
					cnt_q   <= '0;
				end
				D_DIV: begin
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(DW - 1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					neg_q  <= diff[DW-1];
					mag_q  <= diff[DW-1] ? DW'(-diff) : DW'(diff);
					tn_q   <= tn;
					dt_q   <= dt;
					base_q <= base;
				end
			end
			D_MUL: begin
				lo_q <= (HW+DW)'(tn_q[HW-1:0]) * (HW+DW)'(mag_q);
				hi_q <= (LW+DW)'(tn_q[UW-1:HW]) * (LW+DW)'(mag_q);
			end
			D_SUM: begin
				rem_q <= NW'(lo_q) + (NW'(hi_q) << HW);
				dsh_q <= NW'(dt_q) << (DW - 1);
				quo_q <= '0;
			end
			D_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	// negative numerator rounds away from zero when a remainder is left
	always_comb begin
		qs = $signed({1'b0, quo_q});
		if (neg_q) begin
			qs = -(qs + (DW+1)'(rem_q != '0));
		end
		sum = (DW+1)'(base_q) + qs;
	end

	assign done   = state_q == D_FIN;
	assign result = sum[W-1:0];

endmodule

// ===== design/nearest_segment_intersection_top.sv =====
// ----------------------------------------------------------------------------
// nearest_segment_intersection_top
// segment table with clear, append and nearest-hit query
// ----------------------------------------------------------------------------
// clear and append: the word goes to ST_FIN, from which the result is registered
// query: the scan reads each stored segment; with hits the point divide follows,
//   a hit can hold the scan during its t compare, and the divide takes one
//   quotient bit per cycle
// one item in flight; the next word is taken once the result is registered
// reset clears the segment count; table contents are not cleared
module nearest_segment_intersection_top #(
	parameter int MAX_SEGMENTS = nsi_pkg::MAX_SEGMENTS_DEF,
	parameter int COORD_WIDTH  = nsi_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    kind,
	input  logic signed [COORD_WIDTH-1:0] x_start,
	input  logic signed [COORD_WIDTH-1:0] y_start,
	input  logic signed [COORD_WIDTH-1:0] x_end,
	input  logic signed [COORD_WIDTH-1:0] y_end,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          status,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y
);

	localparam int W  = COORD_WIDTH;
	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int UW = 2 * (W + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	logic   accept;
	logic   full;
	logic   wr_en;
	logic   scan_go_q;
	logic   div_go;
	logic [CW-1:0] count_q;
	logic signed [W-1:0] xs_q, ys_q, xe_q, ye_q;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [4*W-1:0]       rd_data;
	nsi_pkg::scan_stat_t  stat;
	logic [UW-1:0]        best_tn, best_dt;
	logic                 x_done, y_done;
	logic signed [W-1:0]  px, py;

	logic                 status_q, hit_q;
	logic signed [W-1:0]  px_q, py_q;
	logic                 out_v_q, out_status_q, out_hit_q;
	logic signed [W-1:0]  out_px_q, out_py_q;

	assign item_stall = state_q != ST_IDLE;
	assign accept     = item_valid & ~item_stall;
	assign full       = count_q >= CW'(MAX_SEGMENTS);
	assign wr_en      = accept & (kind == nsi_pkg::KIND_APPEND) & ~full;
	assign div_go     = (state_q == ST_SCAN) & stat.done & stat.any;

	nsi_table #(
		.DEPTH (MAX_SEGMENTS),
		.AW    (AW),
		.DW    (4 * W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({x_start, y_start, x_end, y_end}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nsi_scan #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_go_q),
		.count   (count_q),
		.x_start (xs_q),
		.y_start (ys_q),
		.x_end   (xe_q),
		.y_end   (ye_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.stat    (stat),
		.best_tn (best_tn),
		.best_dt (best_dt)
	);

	nsi_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.tn     (best_tn),
		.dt     (best_dt),
		.base   (xs_q),
		.tip    (xe_q),
		.done   (x_done),
		.result (px)
	);

	nsi_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.tn     (best_tn),
		.dt     (best_dt),
		.base   (ys_q),
		.tip    (ye_q),
		.done   (y_done),
		.result (py)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			scan_go_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			scan_go_q <= accept & (kind == nsi_pkg::KIND_QUERY);
			if (state_q == ST_FIN && (!out_v_q || !result_stall)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !result_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							nsi_pkg::KIND_CLEAR: begin
								count_q <= '0;
								state_q <= ST_FIN;
							end
							nsi_pkg::KIND_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_FIN;
							end
							nsi_pkg::KIND_QUERY: begin
								state_q <= ST_SCAN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_SCAN: begin
					if (stat.done) begin
						state_q <= stat.any ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (x_done && y_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_v_q || !result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_q     <= x_start;
			ys_q     <= y_start;
			xe_q     <= x_end;
			ye_q     <= y_end;
			status_q <= ((kind == nsi_pkg::KIND_APPEND) && full) ?
				nsi_pkg::STATUS_FULL : nsi_pkg::STATUS_OK;
			hit_q    <= 1'b0;
			px_q     <= '0;
			py_q     <= '0;
		end
		if (state_q == ST_DIV && x_done && y_done) begin
			hit_q <= 1'b1;
			px_q  <= px;
			py_q  <= py;
		end
		if (state_q == ST_FIN && (!out_v_q || !result_stall)) begin
			out_status_q <= status_q;
			out_hit_q    <= hit_q;
			out_px_q     <= px_q;
			out_py_q     <= py_q;
		end
	end

	assign result_valid = out_v_q;
	assign status       = out_status_q;
	assign hit          = out_hit_q;
	assign point_x      = out_px_q;
	assign point_y      = out_py_q;

endmodule

// ===== design/nsi_checker.sv =====
// ----------------------------------------------------------------------------
// nsi_checker
// port-level checks of the nearest segment intersection block
// ----------------------------------------------------------------------------
module nsi_checker #(
	parameter int COORD_WIDTH = nsi_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic                          status,
	input logic                          hit,
	input logic signed [COORD_WIDTH-1:0] point_x,
	input logic signed [COORD_WIDTH-1:0] point_y
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) && $stable(hit)
			&& $stable(point_x) && $stable(point_y))
		else $error("stalled result changed");

	// a dropped append never reports a hit
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(status && hit))
		else $error("full status together with hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !hit |-> point_x == '0 && point_y == '0)
		else $error("point not zero without hit");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("word taken while busy");

endmodule

bind nearest_segment_intersection_top nsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_nsi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.status       (status),
	.hit          (hit),
	.point_x      (point_x),
	.point_y      (point_y)
);
